// ===== hw/rtl/pedal_sensor_plausibility_map_core_assert.svh =====
// ----------------------------------------------------------------------------
// Pedal sensor plausibility map assertion macros
// Shorthand for the concurrent checks on the core's ports, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef PEDAL_SENSOR_PLAUSIBILITY_MAP_CORE_ASSERT_SVH
`define PEDAL_SENSOR_PLAUSIBILITY_MAP_CORE_ASSERT_SVH

// Check that is switched off while reset is high.
`define PSP_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: check failed");

// Check that also covers the reset cycles.
`define PSP_ASSERT_RST(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("%m: check failed during or after reset");

`endif

// ===== hw/rtl/psp_pkg.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor plausibility map package
// Payload types, configuration record, register codes and curve coefficients.
// ----------------------------------------------------------------------------
package psp_pkg;

   // One input transfer: a pair of raw sensor samples and the previous check's flag.
   typedef struct packed {
      logic [11:0] sample_one;
      logic [11:0] sample_two;
      logic        prev_plausible;
   } req_type;

   // One result transfer.
   typedef struct packed {
      logic [9:0] pedal_value;
      logic       implausible;
      logic       check_failed;
   } rsp_type;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic [11:0] offset_one;
      logic [11:0] offset_two;
      logic [23:0] span_gain_one;
      logic [23:0] span_gain_two;
      logic [23:0] travel_gain_one;
      logic [23:0] travel_gain_two;
      logic [15:0] deviation_limit;
      logic [1:0]  curve_select;
   } cfg_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_ONE      = 3'd0,
      CSR_OFFSET_TWO      = 3'd1,
      CSR_SPAN_GAIN_ONE   = 3'd2,
      CSR_SPAN_GAIN_TWO   = 3'd3,
      CSR_TRAVEL_GAIN_ONE = 3'd4,
      CSR_TRAVEL_GAIN_TWO = 3'd5,
      CSR_DEVIATION_LIMIT = 3'd6,
      CSR_CURVE_SELECT    = 3'd7
   } csr_index_type;

   localparam cfg_type CFG_RESET = '{
      offset_one:      12'd0,
      offset_two:      12'd0,
      span_gain_one:   24'd4096,
      span_gain_two:   24'd4096,
      travel_gain_one: 24'd65536,
      travel_gain_two: 24'd65536,
      deviation_limit: 16'd6554,
      curve_select:    2'd0
   };

   // Curve evaluation: five Horner terms in signed Q.40.
   localparam int HORNER_TERMS = 5;
   localparam int FRAC_BITS    = 40;
   localparam logic signed [63:0] HORNER_BOUND = 64'sh4000_0000_0000_0000;

   // Curve coefficients, highest order first, in signed Q.40.
   function automatic logic signed [63:0] curve_coef(input logic [1:0] sel,
                                                     input logic [2:0] idx);
      logic signed [63:0] coef;
      coef = 64'sd0;
      case (sel)
         2'd0: begin
            case (idx)
               3'd3:    coef = 64'sd1099511627776;
               default: coef = 64'sd0;
            endcase
         end
         2'd1: begin
            case (idx)
               3'd0:    coef = -64'sd2520;
               3'd1:    coef = 64'sd3283264;
               3'd2:    coef = -64'sd629928537;
               3'd3:    coef = 64'sd909933134812;
               3'd4:    coef = -64'sd876991417393;
               default: coef = 64'sd0;
            endcase
         end
         2'd2: begin
            case (idx)
               3'd0:    coef = 64'sd16035;
               3'd1:    coef = -64'sd10740600;
               3'd2:    coef = 64'sd2603704619;
               3'd3:    coef = 64'sd477618543071;
               3'd4:    coef = 64'sd218157069003;
               default: coef = 64'sd0;
            endcase
         end
         default: begin
            case (idx)
               3'd0:    coef = 64'sd12599;
               3'd1:    coef = -64'sd6948303;
               3'd2:    coef = 64'sd1271310320;
               3'd3:    coef = 64'sd624801845625;
               3'd4:    coef = 64'sd327235603505;
               default: coef = 64'sd0;
            endcase
         end
      endcase
      return coef;
   endfunction

endpackage

// ===== hw/rtl/psp_front.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor plausibility map front end
// Accepts sample pairs, sums each sensor over a window and hands closed
// windows to the queue.
// ----------------------------------------------------------------------------
module psp_front #(
   parameter int SAMPLE_PAIRS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  psp_pkg::req_type      req_data,
   input  logic                  win_full,
   output logic                  win_push,
   output logic [2*(12+$clog2(SAMPLE_PAIRS)):0] win_data
);

   localparam int SUM_W = 12 + $clog2(SAMPLE_PAIRS);
   localparam int CNT_W = (SAMPLE_PAIRS > 1) ? $clog2(SAMPLE_PAIRS) : 1;
   localparam logic [CNT_W-1:0] LAST_PAIR = CNT_W'(SAMPLE_PAIRS - 1);

   logic [SUM_W-1:0] sum_one_ff, sum_one_in, sum_one_add;
   logic [SUM_W-1:0] sum_two_ff, sum_two_in, sum_two_add;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             last_pair;

   // A transfer is taken whenever the queue has room.
   assign req_stall = win_full;
   assign accept    = req_valid && !win_full;
   assign last_pair = (count_ff == LAST_PAIR);

   assign sum_one_add = sum_one_ff + SUM_W'(req_data.sample_one);
   assign sum_two_add = sum_two_ff + SUM_W'(req_data.sample_two);

   // The last pair of a window closes it and pushes the totals.
   assign win_push = accept && last_pair;
   assign win_data = {sum_one_add, sum_two_add, req_data.prev_plausible};

   // Next accumulator state: restart after a closed window.
   always_comb begin
      sum_one_in = sum_one_ff;
      sum_two_in = sum_two_ff;
      count_in   = count_ff;
      if (accept) begin
         if (last_pair) begin
            sum_one_in = '0;
            sum_two_in = '0;
            count_in   = '0;
         end else begin
            sum_one_in = sum_one_add;
            sum_two_in = sum_two_add;
            count_in   = count_ff + CNT_W'(1);
         end
      end
   end

   // Accumulator registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_one_ff <= '0;
         sum_two_ff <= '0;
         count_ff   <= '0;
      end else begin
         sum_one_ff <= sum_one_in;
         sum_two_ff <= sum_two_in;
         count_ff   <= count_in;
      end
   end

endmodule

// ===== hw/rtl/psp_queue.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor plausibility map window queue
// Two-entry queue of closed window totals between front end and back end.
// ----------------------------------------------------------------------------
module psp_queue #(
   parameter int WIDTH = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ===== hw/rtl/psp_back.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor plausibility map back end
// Sequencer that averages a closed window, runs the plausibility check,
// converts to travel and evaluates the pedal curve with one shared step.
// ----------------------------------------------------------------------------
module psp_back #(
   parameter int SAMPLE_PAIRS = 8,
   parameter int OUT_MAX      = 1000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  psp_pkg::cfg_type      cfg,
   input  logic                  win_ready,
   input  logic [2*(12+$clog2(SAMPLE_PAIRS)):0] win_data,
   output logic                  win_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output psp_pkg::rsp_type      rsp_data
);

   localparam int SUM_W       = 12 + $clog2(SAMPLE_PAIRS);
   localparam int LOG_P       = $clog2(SAMPLE_PAIRS);
   localparam int RECIP_SHIFT = SUM_W + LOG_P;
   localparam int RECIP_W     = SUM_W + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT)
      + 64'(SAMPLE_PAIRS) - 64'd1) / 64'(SAMPLE_PAIRS));
   localparam int OUT_W  = $clog2(OUT_MAX + 1);
   localparam logic [OUT_W-1:0] OUT_LIMIT = OUT_W'(OUT_MAX);
   localparam int PLO_W  = 32 + OUT_W;
   localparam int PHI_W  = 31 + OUT_W;
   localparam int FULL_W = 64 + OUT_W;
   localparam logic [FULL_W-1:0] FULL_BOUND = FULL_W'(64'h4000_0000_0000_0000);
   localparam logic [62:0] MAG_BOUND = 63'h4000_0000_0000_0000;
   localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (psp_pkg::FRAC_BITS - 1);
   localparam logic [2:0] LAST_TERM = 3'(psp_pkg::HORNER_TERMS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG,
      ST_SCALE,
      ST_CHECK,
      ST_MIX,
      ST_ABS,
      ST_MLO,
      ST_MHI,
      ST_SAT,
      ST_ADD,
      ST_ROUND,
      ST_DONE
   } state_type;

   state_type               state_ff;
   logic [SUM_W-1:0]        sum_one_ff, sum_two_ff;
   logic                    prev_ff;
   logic [11:0]             avg_one_ff, avg_two_ff, avg_one_in, avg_two_in;
   logic signed [36:0]      frac_one_ff, frac_two_ff, frac_one_in, frac_two_in;
   logic signed [36:0]      trav_one_ff, trav_two_ff, trav_one_in, trav_two_in;
   logic                    failed_ff, failed_in;
   logic                    fault_ff, fault_in;
   logic [OUT_W-1:0]        t_one_ff, t_two_ff, t_one_in, t_two_in;
   logic [OUT_W-1:0]        x_ff, x_in;
   logic [2:0]              term_ff;
   logic signed [63:0]      acc_ff, acc_in;
   logic [62:0]             mag_ff, mag_in;
   logic                    neg_ff;
   logic [PLO_W-1:0]        plo_ff, plo_in;
   logic [PHI_W-1:0]        phi_ff, phi_in;
   logic signed [63:0]      prod_ff, prod_in;
   logic [9:0]              pedal_ff, pedal_in;
   logic                    rsp_valid_ff;
   psp_pkg::rsp_type        rsp_data_ff;

   logic [PROD_W-1:0]       avg_prod_one, avg_prod_two;
   logic signed [12:0]      delta_one, delta_two;
   logic signed [37:0]      frac_diff;
   logic [37:0]             frac_dist;
   logic [FULL_W-1:0]       full_prod;
   logic [62:0]             sat_mag;
   logic signed [63:0]      add_sum;
   logic signed [63:0]      rounded;
   logic [23:0]             rounded_int;

   // Raw-to-travel conversion: round to nearest, keep 0..OUT_MAX.
   function automatic logic [OUT_W-1:0] travel_clamp(input logic signed [36:0] p);
      logic [36:0] biased;
      logic [OUT_W-1:0] t;
      biased = $unsigned(p) + 37'd32768;
      if (p <= 37'sd0) begin
         t = '0;
      end else if (biased[36:16] > 21'(OUT_MAX)) begin
         t = OUT_LIMIT;
      end else begin
         t = biased[16 +: OUT_W];
      end
      return t;
   endfunction

   // Window average: multiply by the reciprocal of the window length.
   assign avg_prod_one = PROD_W'(sum_one_ff) * PROD_W'(RECIP);
   assign avg_prod_two = PROD_W'(sum_two_ff) * PROD_W'(RECIP);
   assign avg_one_in   = avg_prod_one[RECIP_SHIFT +: 12];
   assign avg_two_in   = avg_prod_two[RECIP_SHIFT +: 12];

   // Offset removal and the four scalings.
   assign delta_one   = $signed({1'b0, avg_one_ff}) - $signed({1'b0, cfg.offset_one});
   assign delta_two   = $signed({1'b0, avg_two_ff}) - $signed({1'b0, cfg.offset_two});
   assign frac_one_in = 37'(delta_one) * 37'($signed({1'b0, cfg.span_gain_one}));
   assign frac_two_in = 37'(delta_two) * 37'($signed({1'b0, cfg.span_gain_two}));
   assign trav_one_in = 37'(delta_one) * 37'($signed({1'b0, cfg.travel_gain_one}));
   assign trav_two_in = 37'(delta_two) * 37'($signed({1'b0, cfg.travel_gain_two}));

   // Plausibility: distance between the two travel fractions.
   assign frac_diff = 38'(frac_one_ff) - 38'(frac_two_ff);
   assign frac_dist = frac_diff[37] ? $unsigned(-frac_diff) : $unsigned(frac_diff);
   assign failed_in = frac_dist > 38'({cfg.deviation_limit, 8'd0});
   assign fault_in  = failed_ff && !prev_ff;
   assign t_one_in  = travel_clamp(trav_one_ff);
   assign t_two_in  = travel_clamp(trav_two_ff);
   assign x_in      = OUT_W'(({1'b0, t_one_ff} + {1'b0, t_two_ff}) >> 1);

   // Horner step: magnitude, two half products, saturation, coefficient add.
   assign mag_in    = acc_ff[63] ? 63'($unsigned(-acc_ff)) : acc_ff[62:0];
   assign plo_in    = PLO_W'(mag_ff[31:0]) * PLO_W'(x_ff);
   assign phi_in    = PHI_W'(mag_ff[62:32]) * PHI_W'(x_ff);
   assign full_prod = FULL_W'({phi_ff, 32'd0}) + FULL_W'(plo_ff);
   assign sat_mag   = (full_prod > FULL_BOUND) ? MAG_BOUND : full_prod[62:0];
   assign prod_in   = neg_ff ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});
   assign add_sum   = prod_ff + psp_pkg::curve_coef(cfg.curve_select, term_ff);

   always_comb begin
      if (add_sum > psp_pkg::HORNER_BOUND) begin
         acc_in = psp_pkg::HORNER_BOUND;
      end else if (add_sum < -psp_pkg::HORNER_BOUND) begin
         acc_in = -psp_pkg::HORNER_BOUND;
      end else begin
         acc_in = add_sum;
      end
   end

   // Final rounding out of Q.40 and clamp to the output range.
   assign rounded     = acc_ff + ROUND_HALF;
   assign rounded_int = rounded[63:40];

   always_comb begin
      if (rounded[63]) begin
         pedal_in = '0;
      end else if (rounded_int > 24'(OUT_MAX)) begin
         pedal_in = 10'(24'(OUT_MAX));
      end else begin
         pedal_in = rounded_int[9:0];
      end
   end

   assign win_pop   = (state_ff == ST_IDLE) && win_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer with the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A taken result empties the output register unless ST_DONE refills it.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (win_ready) begin
                  sum_one_ff <= win_data[2*SUM_W:SUM_W+1];
                  sum_two_ff <= win_data[SUM_W:1];
                  prev_ff    <= win_data[0];
                  state_ff   <= ST_AVG;
               end
            end
            ST_AVG: begin
               avg_one_ff <= avg_one_in;
               avg_two_ff <= avg_two_in;
               state_ff   <= ST_SCALE;
            end
            ST_SCALE: begin
               frac_one_ff <= frac_one_in;
               frac_two_ff <= frac_two_in;
               trav_one_ff <= trav_one_in;
               trav_two_ff <= trav_two_in;
               state_ff    <= ST_CHECK;
            end
            ST_CHECK: begin
               failed_ff <= failed_in;
               t_one_ff  <= t_one_in;
               t_two_ff  <= t_two_in;
               state_ff  <= ST_MIX;
            end
            ST_MIX: begin
               fault_ff <= fault_in;
               x_ff     <= x_in;
               acc_ff   <= '0;
               term_ff  <= '0;
               if (fault_in) begin
                  pedal_ff <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_ABS;
               end
            end
            ST_ABS: begin
               mag_ff   <= mag_in;
               neg_ff   <= acc_ff[63];
               state_ff <= ST_MLO;
            end
            ST_MLO: begin
               plo_ff   <= plo_in;
               state_ff <= ST_MHI;
            end
            ST_MHI: begin
               phi_ff   <= phi_in;
               state_ff <= ST_SAT;
            end
            ST_SAT: begin
               prod_ff  <= prod_in;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               acc_ff  <= acc_in;
               term_ff <= term_ff + 3'd1;
               if (term_ff == LAST_TERM) begin
                  state_ff <= ST_ROUND;
               end else begin
                  state_ff <= ST_ABS;
               end
            end
            ST_ROUND: begin
               pedal_ff <= pedal_in;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_data_ff.pedal_value  <= pedal_ff;
                  rsp_data_ff.implausible  <= fault_ff;
                  rsp_data_ff.check_failed <= failed_ff;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/pedal_sensor_plausibility_map_core.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor plausibility map core
// Window averaging of two pedal sensors, plausibility check and pedal curve.
// ----------------------------------------------------------------------------
// Sample pairs are taken one per cycle whenever the two-entry window queue
// has room; every SAMPLE_PAIRS pairs close a window, and one result follows
// for each window. The back end takes a window from the queue, averages,
// scales and checks it, runs the five Horner terms through one shared
// multiply step of two half products, rounds, and loads the output
// register; a faulted window skips the curve. When a window takes no less
// time to fill than the back end spends on one and results are not
// stalled, input runs at one pair per cycle; with shorter windows the curve
// sequencer sets the pace. Configuration is to be written by the user only
// while no window is in flight; the block itself does not enforce this.
module pedal_sensor_plausibility_map_core #(
   parameter int SAMPLE_PAIRS = 8,
   parameter int OUT_MAX      = 1000
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  psp_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output psp_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [psp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [psp_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int WIN_W = 2 * (12 + $clog2(SAMPLE_PAIRS)) + 1;

   psp_pkg::cfg_type cfg_ff;
   logic             win_full, win_push, win_pop, win_ready;
   logic [WIN_W-1:0] win_push_data, win_pop_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= psp_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         case (psp_pkg::csr_index_type'(csr_index))
            psp_pkg::CSR_OFFSET_ONE:      cfg_ff.offset_one      <= csr_data[11:0];
            psp_pkg::CSR_OFFSET_TWO:      cfg_ff.offset_two      <= csr_data[11:0];
            psp_pkg::CSR_SPAN_GAIN_ONE:   cfg_ff.span_gain_one   <= csr_data[23:0];
            psp_pkg::CSR_SPAN_GAIN_TWO:   cfg_ff.span_gain_two   <= csr_data[23:0];
            psp_pkg::CSR_TRAVEL_GAIN_ONE: cfg_ff.travel_gain_one <= csr_data[23:0];
            psp_pkg::CSR_TRAVEL_GAIN_TWO: cfg_ff.travel_gain_two <= csr_data[23:0];
            psp_pkg::CSR_DEVIATION_LIMIT: cfg_ff.deviation_limit <= csr_data[15:0];
            psp_pkg::CSR_CURVE_SELECT:    cfg_ff.curve_select    <= csr_data[1:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Window accumulation.
   psp_front #(
      .SAMPLE_PAIRS(SAMPLE_PAIRS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .win_full  (win_full),
      .win_push  (win_push),
      .win_data  (win_push_data)
   );

   // Closed windows waiting for the back end.
   psp_queue #(
      .WIDTH(WIN_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (win_push),
      .push_data (win_push_data),
      .full      (win_full),
      .pop       (win_pop),
      .pop_data  (win_pop_data),
      .not_empty (win_ready)
   );

   // Check, travel conversion and curve.
   psp_back #(
      .SAMPLE_PAIRS(SAMPLE_PAIRS),
      .OUT_MAX     (OUT_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .win_ready (win_ready),
      .win_data  (win_pop_data),
      .win_pop   (win_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/psp_checker.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor plausibility map port checker
// Watches the core's ports and checks results against closed windows and stalls.
// ----------------------------------------------------------------------------
`include "pedal_sensor_plausibility_map_core_assert.svh"

module psp_checker #(
   parameter int SAMPLE_PAIRS = 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input psp_pkg::rsp_type rsp_data
);

   localparam int CNT_W = (SAMPLE_PAIRS > 1) ? $clog2(SAMPLE_PAIRS) : 1;
   localparam logic [CNT_W-1:0] LAST_PAIR = CNT_W'(SAMPLE_PAIRS - 1);

   logic [CNT_W-1:0] pair_ff;
   logic [3:0]       pending_ff;
   logic             window_close, result_take;

   assign window_close = req_valid && !req_stall && (pair_ff == LAST_PAIR);
   assign result_take  = rsp_valid && !rsp_stall;

   // Count closed windows that have not yet produced a result.
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff    <= '0;
         pending_ff <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            pair_ff <= window_close ? '0 : pair_ff + CNT_W'(1);
         end
         if (window_close && !result_take) begin
            pending_ff <= pending_ff + 4'd1;
         end else if (result_take && !window_close) begin
            pending_ff <= pending_ff - 4'd1;
         end
      end
   end

   // A result is only offered for a window that has closed.
   `PSP_ASSERT(result_has_window, rsp_valid |-> (pending_ff != 4'd0))

   // Reset empties the output register.
   `PSP_ASSERT_RST(reset_clears_output, reset |=> !rsp_valid)

   // A stalled result stays offered.
   `PSP_ASSERT(stalled_result_held, rsp_valid && rsp_stall |=> rsp_valid)

   // A stalled result keeps its payload.
   `PSP_ASSERT(stalled_payload_held, rsp_valid && rsp_stall |=> $stable(rsp_data))

endmodule

bind pedal_sensor_plausibility_map_core psp_checker #(
   .SAMPLE_PAIRS(SAMPLE_PAIRS)
) u_psp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/pedal_sensor_plausibility_map_checker.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor plausibility map checker
// Watches the sample, result and register ports of the core. It keeps its own
// copy of the registers and of the window sums. For every closed window it
// predicts the result, and it compares each result transfer, field by field,
// with the oldest prediction.
// ----------------------------------------------------------------------------
module pedal_sensor_plausibility_map_checker #(
   parameter int SAMPLE_PAIRS = 8,
   parameter int OUT_MAX      = 1000
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  psp_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  psp_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [psp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psp_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              mismatch_count,
   output int                              results_pending
);

   localparam int SUM_W = 12 + $clog2(SAMPLE_PAIRS);
   localparam longint HORNER_LIMIT = 64'sh4000_0000_0000_0000;

   // Pedal curves in signed Q.40, highest order first: linear, blue, green, red.
   localparam longint CURVE_Q40 [4][5] = '{
      '{64'sd0, 64'sd0, 64'sd0, 64'sd1099511627776, 64'sd0},
      '{-64'sd2520, 64'sd3283264, -64'sd629928537, 64'sd909933134812,
        -64'sd876991417393},
      '{64'sd16035, -64'sd10740600, 64'sd2603704619, 64'sd477618543071,
        64'sd218157069003},
      '{64'sd12599, -64'sd6948303, 64'sd1271310320, 64'sd624801845625,
        64'sd327235603505}
   };

   psp_pkg::cfg_type   regs;
   logic [SUM_W-1:0]   sum_one;
   logic [SUM_W-1:0]   sum_two;
   int                 pairs_in_window;
   int                 results_seen;
   psp_pkg::rsp_type   window_result_q[$];

   // Raw offset-corrected reading to travel units, rounded half away from zero.
   function automatic longint travel_units(input longint delta, input logic [23:0] gain);
      longint p;
      longint r;
      p = delta * longint'(gain);
      if (p >= 0) begin
         r = (p + 32768) >>> 16;
      end else begin
         r = -((-p + 32768) >>> 16);
      end
      if (r < 0) begin
         r = 0;
      end else if (r > OUT_MAX) begin
         r = OUT_MAX;
      end
      return r;
   endfunction

   // Result of one closed window from the two averages and the register set.
   function automatic psp_pkg::rsp_type pedal_of_window(input int avg_one, input int avg_two,
                                                         input logic prev_pass,
                                                         input psp_pkg::cfg_type c);
      longint           d_one;
      longint           d_two;
      longint           frac_gap;
      longint           s;
      longint           prod;
      longint           q;
      bit [63:0]        mag;
      bit [63:0]        x;
      bit [63:0]        bound;
      logic             neg;
      psp_pkg::rsp_type r;
      d_one = longint'(avg_one) - longint'(c.offset_one);
      d_two = longint'(avg_two) - longint'(c.offset_two);
      frac_gap = d_one * longint'(c.span_gain_one) - d_two * longint'(c.span_gain_two);
      if (frac_gap < 0) begin
         frac_gap = -frac_gap;
      end
      r = '0;
      r.check_failed = frac_gap > (longint'(c.deviation_limit) <<< 8);
      r.implausible  = r.check_failed && !prev_pass;
      if (!r.implausible) begin
         x = 64'((travel_units(d_one, c.travel_gain_one)
                  + travel_units(d_two, c.travel_gain_two)) / 2);
         bound = 64'(HORNER_LIMIT);
         s = 0;
         // Horner steps with the running sum held within the saturation bound.
         for (int i = 0; i < 5; i++) begin
            neg = s < 0;
            mag = neg ? 64'(-s) : 64'(s);
            if (x != 0 && mag > bound / x) begin
               prod = HORNER_LIMIT;
            end else begin
               prod = longint'(mag * x);
            end
            if (neg) begin
               prod = -prod;
            end
            s = prod + CURVE_Q40[c.curve_select][i];
            if (s > HORNER_LIMIT) begin
               s = HORNER_LIMIT;
            end else if (s < -HORNER_LIMIT) begin
               s = -HORNER_LIMIT;
            end
         end
         s = s + (longint'(1) <<< 39);
         if (s < 0) begin
            q = 0;
         end else begin
            q = s >>> 40;
            if (q > OUT_MAX) begin
               q = OUT_MAX;
            end
         end
         r.pedal_value = q[9:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("MISMATCH result %0d %s: got %0d, expected %0d", results_seen, field, got, want);
      mismatch_count++;
   endtask

   // Result check first: a result leaving at this edge never belongs to a
   // window that closes at the same edge.
   always @(posedge clock) begin
      psp_pkg::rsp_type want;
      if (reset) begin
         regs = psp_pkg::CFG_RESET;
         sum_one = '0;
         sum_two = '0;
         pairs_in_window = 0;
         results_seen = 0;
         mismatch_count = 0;
         window_result_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (window_result_q.size() == 0) begin
               report_mismatch("unexpected transfer, pedal_value", rsp_data.pedal_value, -1);
            end else begin
               want = window_result_q.pop_front();
               if (rsp_data.pedal_value !== want.pedal_value)
                  report_mismatch("pedal_value", rsp_data.pedal_value, want.pedal_value);
               if (rsp_data.implausible !== want.implausible)
                  report_mismatch("implausible", rsp_data.implausible, want.implausible);
               if (rsp_data.check_failed !== want.check_failed)
                  report_mismatch("check_failed", rsp_data.check_failed, want.check_failed);
            end
            results_seen++;
         end

         // Accumulate the sample pair; the last pair of a window closes it.
         if (req_valid && !req_stall) begin
            sum_one = sum_one + SUM_W'(req_data.sample_one);
            sum_two = sum_two + SUM_W'(req_data.sample_two);
            pairs_in_window++;
            if (pairs_in_window == SAMPLE_PAIRS) begin
               window_result_q.push_back(pedal_of_window(int'(sum_one) / SAMPLE_PAIRS,
                                                         int'(sum_two) / SAMPLE_PAIRS,
                                                         req_data.prev_plausible, regs));
               sum_one = '0;
               sum_two = '0;
               pairs_in_window = 0;
            end
         end

         // Register writes keep only the bits of the addressed register.
         if (csr_wr_en) begin
            case (psp_pkg::csr_index_type'(csr_index))
               psp_pkg::CSR_OFFSET_ONE:      regs.offset_one      = csr_data[11:0];
               psp_pkg::CSR_OFFSET_TWO:      regs.offset_two      = csr_data[11:0];
               psp_pkg::CSR_SPAN_GAIN_ONE:   regs.span_gain_one   = csr_data[23:0];
               psp_pkg::CSR_SPAN_GAIN_TWO:   regs.span_gain_two   = csr_data[23:0];
               psp_pkg::CSR_TRAVEL_GAIN_ONE: regs.travel_gain_one = csr_data[23:0];
               psp_pkg::CSR_TRAVEL_GAIN_TWO: regs.travel_gain_two = csr_data[23:0];
               psp_pkg::CSR_DEVIATION_LIMIT: regs.deviation_limit = csr_data[15:0];
               psp_pkg::CSR_CURVE_SELECT:    regs.curve_select    = csr_data[1:0];
               default: ;
            endcase
         end
      end
      results_pending = window_result_q.size();
   end

endmodule

// ===== tb/tb_pedal_sensor_plausibility_map_core.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor plausibility map core testbench
// Drives sample pairs and register settings into the core with random gaps
// and result stalls. A directed run of zero, full-scale and faulted windows
// comes first, then phases of fixed or random settings, each followed by
// windows of correlated sensor pairs and some noise. The checker beside the
// core predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_pedal_sensor_plausibility_map_core;

   localparam int SAMPLE_PAIRS = 8;
   localparam int OUT_MAX      = 1000;
   localparam int ITEM_TARGET  = 1500;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 200000;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   psp_pkg::req_type                req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   psp_pkg::rsp_type                rsp_data;
   logic                            csr_wr_en;
   logic [psp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [psp_pkg::CSR_DATA_W-1:0]  csr_data;

   int   mismatch_count;
   int   results_pending;
   int   items_sent = 0;
   int   cycle_count = 0;
   logic calm_phase = 1'b0;
   logic rsp_took = 1'b0;

   pedal_sensor_plausibility_map_core #(
      .SAMPLE_PAIRS(SAMPLE_PAIRS),
      .OUT_MAX     (OUT_MAX)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   pedal_sensor_plausibility_map_checker #(
      .SAMPLE_PAIRS(SAMPLE_PAIRS),
      .OUT_MAX     (OUT_MAX)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .results_pending(results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case results stop coming.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side: after each transfer draw a new random stall, none in a calm phase.
   always @(posedge clock) begin
      rsp_took <= rsp_valid && !rsp_stall;
   end

   initial begin
      int hold;
      rsp_stall = 1'b0;
      hold = $urandom_range(0, 5);
      forever begin
         @(negedge clock);
         if (rsp_took) begin
            hold = calm_phase ? 0 : $urandom_range(0, 5);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [11:0] clip12(input int v);
      if (v < 0) begin
         return 12'd0;
      end
      if (v > 4095) begin
         return 12'd4095;
      end
      return 12'(v);
   endfunction

   // One sample pair transfer, after a random gap unless the phase is calm.
   task automatic send_pair(input logic [11:0] one, input logic [11:0] two,
                            input logic prev_pass);
      int               gap;
      psp_pkg::req_type pair;
      gap = calm_phase ? 0 : $urandom_range(0, 5);
      pair.sample_one = one;
      pair.sample_two = two;
      pair.prev_plausible = prev_pass;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= pair;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid, let every window result out, then let the core settle.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input psp_pkg::csr_index_type idx,
                            input logic [psp_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
   endtask

   initial begin
      psp_pkg::cfg_type c;
      int               phase;
      int               lvl;
      int               dev;
      int               jit;
      int               s1;
      int               s2;
      int               windows;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed windows at reset settings: all zero, full scale, and a
      // sensor split with a failed previous check, which must fault.
      repeat (SAMPLE_PAIRS) send_pair(12'd0, 12'd0, 1'b0);
      repeat (SAMPLE_PAIRS) send_pair(12'hfff, 12'hfff, 1'b1);
      repeat (SAMPLE_PAIRS) send_pair(12'hfff, 12'd0, 1'b0);
      wait_for_drain();

      // Phases: new register set, then a batch of windows.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase == 0) begin
            c = '1;
         end else if (phase == 1) begin
            c = '0;
         end else if ($urandom_range(0, 3) == 0) begin
            c.offset_one      = 12'($urandom);
            c.offset_two      = 12'($urandom);
            c.span_gain_one   = 24'($urandom);
            c.span_gain_two   = 24'($urandom);
            c.travel_gain_one = 24'($urandom);
            c.travel_gain_two = 24'($urandom);
            c.deviation_limit = 16'($urandom);
            c.curve_select    = 2'($urandom);
         end else begin
            c.offset_one      = 12'($urandom_range(0, 800));
            c.offset_two      = 12'($urandom_range(0, 800));
            c.span_gain_one   = 24'($urandom_range(2048, 8192));
            c.span_gain_two   = 24'($urandom_range(2048, 8192));
            c.travel_gain_one = 24'($urandom_range(8000, 40000));
            c.travel_gain_two = 24'($urandom_range(8000, 40000));
            c.deviation_limit = 16'($urandom_range(0, 20000));
            c.curve_select    = 2'($urandom_range(0, 3));
         end

         // Junk in the unused upper data bits must be dropped by the core.
         write_reg(psp_pkg::CSR_OFFSET_ONE,      {12'($urandom), c.offset_one});
         write_reg(psp_pkg::CSR_OFFSET_TWO,      {12'($urandom), c.offset_two});
         write_reg(psp_pkg::CSR_SPAN_GAIN_ONE,   c.span_gain_one);
         write_reg(psp_pkg::CSR_SPAN_GAIN_TWO,   c.span_gain_two);
         write_reg(psp_pkg::CSR_TRAVEL_GAIN_ONE, c.travel_gain_one);
         write_reg(psp_pkg::CSR_TRAVEL_GAIN_TWO, c.travel_gain_two);
         write_reg(psp_pkg::CSR_DEVIATION_LIMIT, {8'($urandom), c.deviation_limit});
         write_reg(psp_pkg::CSR_CURVE_SELECT,    {22'($urandom), c.curve_select});
         @(negedge clock);
         csr_wr_en <= 1'b0;

         calm_phase = ($urandom_range(0, 3) == 0);
         windows = $urandom_range(4, 16);
         repeat (windows) begin
            if ($urandom_range(0, 99) < 85) begin
               // Two sensors tracking one pedal position with a fixed skew,
               // small most of the time and now and then beyond the limit.
               lvl = $urandom_range(0, 4095);
               dev = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1500)
                                                 : $urandom_range(0, 300);
               if ($urandom_range(0, 1) == 1) begin
                  dev = -dev;
               end
               repeat (SAMPLE_PAIRS) begin
                  jit = $urandom_range(0, 40);
                  s1 = lvl + jit - 20;
                  jit = $urandom_range(0, 40);
                  s2 = s1 + dev + jit - 20;
                  send_pair(clip12(s1), clip12(s2), 1'($urandom_range(0, 1)));
               end
            end else begin
               repeat (SAMPLE_PAIRS) begin
                  send_pair(12'($urandom), 12'($urandom), 1'($urandom));
               end
            end
         end
         wait_for_drain();
         phase++;
      end

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
